// ===== rtl/dpw_pkg.sv =====
// ----------------------------------------------------------------------------
// dpw_pkg
// shared widths, reset values, register codes and request types of the
// dpw pulse oscillator
// ----------------------------------------------------------------------------
package dpw_pkg;

    // field and register widths
    localparam int FREQ_W     = 24;
    localparam int SP_W       = 28;
    localparam int SPH_W      = 24;
    localparam int PW_W       = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // datapath widths
    localparam int MUL_W  = 32;   // shared multiplier operand width
    localparam int PROD_W = 64;   // shared multiplier product width
    localparam int N31_W  = 35;   // normalized increment, 31 fraction bits
    localparam int X_W    = 24;   // 1 - n*T in Q.23
    localparam int DEN_W  = 37;   // gain denominator, Q.31
    localparam int SQ_W   = 32;   // phase square, Q1.31 in [0,1]
    localparam int DMAG_W = 33;   // magnitude of the square difference
    localparam int REM_W  = 38;   // divider partial remainder

    // register reset values
    localparam logic [SP_W-1:0]  SP_RESET  = 28'd22906492;
    localparam logic [SPH_W-1:0] SPH_RESET = 24'd0;
    localparam logic [PW_W-1:0]  PW_RESET  = 23'd4194304;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PHASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH   = 2'd2;

    // operands for the shared multiplier
    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    // start request for the divider
    typedef struct packed {
        logic              start;
        logic [DMAG_W-1:0] dmag;
        logic [DEN_W-1:0]  den;
    } t_div_req;

endpackage

// ===== rtl/dpw_mul.sv =====
// ----------------------------------------------------------------------------
// dpw_mul
// shared 32 x 32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module dpw_mul
    import dpw_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = i_req.a * i_req.b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/dpw_div.sv =====
// ----------------------------------------------------------------------------
// dpw_div
// restoring divider, one quotient bit per cycle, for (dmag << (OUT_BITS-2)) / den
// ----------------------------------------------------------------------------
module dpw_div
    import dpw_pkg::*;
#(
    parameter int OUT_BITS = 24
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_div_req            i_req,
    output logic                o_done,
    output logic [OUT_BITS-1:0] o_quot
);

    localparam int CNT_W = $clog2(OUT_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [REM_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [OUT_BITS-1:0] r_low;
    logic [OUT_BITS-1:0] r_quot;

    logic [REM_W-1:0]    w_trial;
    logic                w_fits;

    // shift in the next dividend bit and try the subtraction
    always_comb begin
        w_trial = {r_rem[REM_W-2:0], r_low[OUT_BITS-1]};
        w_fits  = (w_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OUT_BITS);
                r_rem  <= REM_W'(i_req.dmag[DMAG_W-1:2]);
                r_low  <= {i_req.dmag[1:0], {(OUT_BITS-2){1'b0}}};
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem  <= w_fits ? (w_trial - {1'b0, r_den}) : w_trial;
                r_quot <= {r_quot[OUT_BITS-2:0], w_fits};
                r_low  <= {r_low[OUT_BITS-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/dpw_pulse_oscillator.sv =====
// ----------------------------------------------------------------------------
// dpw_pulse_oscillator
// sequence: a request steps through S_MP to S_CK, waits in S_DW for the divider
//   unless the sample is zero or saturated, and S_FIN then loads o_sample
// requests: one at a time, the next is taken once S_FIN has loaded the sample;
//   each takes seven shared products, then one divider quotient bit per cycle
// reset: synchronous; registers, phases and last squares take reset values
// ----------------------------------------------------------------------------
module dpw_pulse_oscillator
    import dpw_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int OUT_BITS   = 24
)(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [FREQ_W-1:0]   i_freq_hz,
    input  logic                       i_restart,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [OUT_BITS-1:0] o_sample,
    // configuration write channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int PB = PHASE_BITS;

    // alignment of a Q1.23 value to the phase format
    localparam int Q_SHL = (PB >= 24) ? PB - 24 : 0;
    localparam int Q_SHR = (PB < 24) ? 24 - PB : 0;
    // alignment of a phase magnitude to 31 fraction bits
    localparam int M_SHL = (PB < 32) ? 32 - PB : 0;
    localparam int M_SHR = (PB > 32) ? PB - 32 : 0;

    localparam logic [OUT_BITS-1:0] LIM_POS = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic [OUT_BITS-1:0] LIM_NEG = {1'b1, {(OUT_BITS-1){1'b0}}};

    // sequencer: at most one shared multiplier product per step, then the divider
    typedef enum logic [3:0] {
        S_IDLE,   // wait for a request
        S_MP,     // issue |f| * T
        S_NA,     // advance phases, keep n
        S_MA,     // issue low part of n * T
        S_MB,     // keep low part, issue high part
        S_MC,     // 1 - n*T
        S_DA,     // issue low part of n * (1 - n*T)
        S_DB,     // keep low part, issue high part
        S_DC,     // denominator, issue square of phase a
        S_SA,     // keep square a, issue square of phase b
        S_SB,     // difference of square differences
        S_CK,     // zero and saturation check, start divider
        S_DW,     // wait for the divider
        S_FIN     // form sample and load the output register
    } t_state;

    // --- a Q1.23 value to a wrapped phase ---
    function automatic logic [PB-1:0] f_q23_phase(input logic [25:0] v);
        logic [PB+25:0] wide;
        logic [PB+25:0] shifted;
        wide    = {{PB{v[25]}}, v};
        shifted = (wide << Q_SHL) >> Q_SHR;
        return shifted[PB-1:0];
    endfunction

    // --- start phase and pulse width to the raw offset sum ---
    function automatic logic [25:0] f_offset(input logic [SPH_W-1:0] sp,
                                             input logic [PW_W-1:0]  pw,
                                             input logic             with_pw);
        logic [25:0] base;
        base = {{2{sp[SPH_W-1]}}, sp};
        return with_pw ? (base + {2'b00, pw, 1'b0}) : base;
    endfunction

    // --- phase magnitude aligned to 31 fraction bits ---
    function automatic logic [MUL_W-1:0] f_m31(input logic [PB-1:0] p);
        logic [PB-1:0]  mag;
        logic [PB+31:0] wide;
        logic [PB+31:0] shifted;
        mag     = p[PB-1] ? (~p + 1'b1) : p;
        wide    = {32'b0, mag};
        shifted = (wide << M_SHL) >> M_SHR;
        return shifted[MUL_W-1:0];
    endfunction

    // control
    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    // configuration registers
    logic [SP_W-1:0]     r_sample_period, n_sample_period;
    logic [SPH_W-1:0]    r_start_phase, n_start_phase;
    logic [PW_W-1:0]     r_pulse_width, n_pulse_width;
    // oscillator state
    logic [PB-1:0]       r_phase_a, n_phase_a;
    logic [PB-1:0]       r_phase_b, n_phase_b;
    logic [SQ_W-1:0]     r_lsq_a, n_lsq_a;
    logic [SQ_W-1:0]     r_lsq_b, n_lsq_b;
    // per-sample working registers
    logic [FREQ_W-1:0]   r_fmag, n_fmag;
    logic                r_fneg, n_fneg;
    logic [N31_W-1:0]    r_n31, n_n31;
    logic [PROD_W-1:0]   r_acc, n_acc;
    logic [X_W-1:0]      r_x, n_x;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [SQ_W-1:0]     r_sa, n_sa;
    logic [DMAG_W-1:0]   r_dmag, n_dmag;
    logic                r_neg, n_neg;
    logic                r_zero, n_zero;
    logic                r_sat, n_sat;
    logic [OUT_BITS-1:0] r_sample, n_sample;

    logic                w_in_acc;
    logic [PROD_W-1:0]   w_prod;
    logic [PROD_W-1:0]   w_sum;
    logic [SQ_W-1:0]     w_sq;
    logic signed [33:0]  w_diff;
    logic [DEN_W-1:0]    w_dmag_q;
    logic [OUT_BITS-1:0] w_quot;
    logic                w_div_done;
    logic [OUT_BITS-1:0] w_result;
    t_mul_req            w_mul_req;
    t_div_req            w_div_req;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_sample    = $signed(r_sample);
    assign w_in_acc    = i_in_valid && o_in_ready;

    // low partial plus high partial shifted up by 32
    assign w_sum    = r_acc + {w_prod[MUL_W-1:0], 32'b0};
    // square in Q1.31: product of two Q.31 magnitudes, scaled back by 2^31
    assign w_sq     = w_prod[62:31];
    // dividend scaled down by 2^OUT_BITS, for the overflow test
    assign w_dmag_q = DEN_W'(r_dmag[DMAG_W-1:2]);

    // (sa - last_a) - (sb - last_b), both differences within +/-2^31
    assign w_diff = ($signed({2'b00, r_sa}) - $signed({2'b00, r_lsq_a}))
                  - ($signed({2'b00, w_sq}) - $signed({2'b00, r_lsq_b}));

    // operand select for the shared multiplier
    always_comb begin
        w_mul_req = '0;
        unique case (r_state)
            S_MP: begin
                w_mul_req.a = MUL_W'(r_fmag);
                w_mul_req.b = MUL_W'(r_sample_period);
            end
            S_MA: begin
                w_mul_req.a = r_n31[MUL_W-1:0];
                w_mul_req.b = MUL_W'(r_sample_period);
            end
            S_MB: begin
                w_mul_req.a = MUL_W'(r_n31[N31_W-1:MUL_W]);
                w_mul_req.b = MUL_W'(r_sample_period);
            end
            S_DA: begin
                w_mul_req.a = r_n31[MUL_W-1:0];
                w_mul_req.b = MUL_W'(r_x);
            end
            S_DB: begin
                w_mul_req.a = MUL_W'(r_n31[N31_W-1:MUL_W]);
                w_mul_req.b = MUL_W'(r_x);
            end
            S_DC: begin
                w_mul_req.a = f_m31(r_phase_a);
                w_mul_req.b = f_m31(r_phase_a);
            end
            S_SA: begin
                w_mul_req.a = f_m31(r_phase_b);
                w_mul_req.b = f_m31(r_phase_b);
            end
            default: begin
                w_mul_req = '0;
            end
        endcase
    end

    dpw_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // divider runs only when the quotient fits in OUT_BITS bits
    always_comb begin
        w_div_req.start = (r_state == S_CK) && (r_dmag != '0) && (w_dmag_q < r_den);
        w_div_req.dmag  = r_dmag;
        w_div_req.den   = r_den;
    end

    dpw_div #(
        .OUT_BITS (OUT_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // sign and saturation of the quotient
    always_comb begin
        if (r_zero) begin
            w_result = '0;
        end else if (r_sat) begin
            w_result = r_neg ? LIM_NEG : LIM_POS;
        end else if (r_neg) begin
            w_result = (w_quot > LIM_NEG) ? LIM_NEG : (~w_quot + 1'b1);
        end else begin
            w_result = (w_quot > LIM_POS) ? LIM_POS : w_quot;
        end
    end

    // next state and register values
    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid;
        n_sample_period = r_sample_period;
        n_start_phase   = r_start_phase;
        n_pulse_width   = r_pulse_width;
        n_phase_a       = r_phase_a;
        n_phase_b       = r_phase_b;
        n_lsq_a         = r_lsq_a;
        n_lsq_b         = r_lsq_b;
        n_fmag          = r_fmag;
        n_fneg          = r_fneg;
        n_n31           = r_n31;
        n_acc           = r_acc;
        n_x             = r_x;
        n_den           = r_den;
        n_sa            = r_sa;
        n_dmag          = r_dmag;
        n_neg           = r_neg;
        n_zero          = r_zero;
        n_sat           = r_sat;
        n_sample        = r_sample;

        // configuration writes, taken in any cycle
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SAMPLE_PERIOD: n_sample_period = i_cfg_data[SP_W-1:0];
                CFG_START_PHASE:   n_start_phase   = i_cfg_data[SPH_W-1:0];
                CFG_PULSE_WIDTH:   n_pulse_width   = i_cfg_data[PW_W-1:0];
                default:           n_sample_period = r_sample_period;
            endcase
        end

        // the consumer takes the pending sample
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_fneg = i_freq_hz[FREQ_W-1];
                    n_fmag = i_freq_hz[FREQ_W-1] ? (~i_freq_hz + 1'b1) : i_freq_hz;
                    // restart reloads phases before this sample advances them
                    if (i_restart) begin
                        n_phase_a = f_q23_phase(f_offset(r_start_phase, r_pulse_width, 1'b0));
                        n_phase_b = f_q23_phase(f_offset(r_start_phase, r_pulse_width, 1'b1));
                        n_lsq_a   = '0;
                        n_lsq_b   = '0;
                    end
                    n_state = S_MP;
                end
            end
            S_MP: begin
                n_state = S_NA;
            end
            S_NA: begin
                // increment is |f|*T scaled to the phase format, wrapping mod 2
                n_phase_a = r_phase_a + w_prod[47:48-PB];
                n_phase_b = r_phase_b + w_prod[47:48-PB];
                n_n31     = w_prod[N31_W+15:16];
                n_state   = S_MA;
            end
            S_MA: begin
                n_state = S_MB;
            end
            S_MB: begin
                n_acc   = w_prod;
                n_state = S_MC;
            end
            S_MC: begin
                // n*T in Q.23 is a 16 bit slice, so stays below 2^16
                n_x     = X_W'(24'h800000 - {8'b0, w_sum[63:48]});
                n_state = S_DA;
            end
            S_DA: begin
                n_state = S_DB;
            end
            S_DB: begin
                n_acc   = w_prod;
                n_state = S_DC;
            end
            S_DC: begin
                n_den   = {w_sum[57:23], 2'b00};
                n_state = S_SA;
            end
            S_SA: begin
                n_sa    = w_sq;
                n_state = S_SB;
            end
            S_SB: begin
                n_lsq_a = r_sa;
                n_lsq_b = w_sq;
                n_dmag  = w_diff[33] ? DMAG_W'(-w_diff) : w_diff[DMAG_W-1:0];
                n_neg   = w_diff[33] ^ r_fneg;
                n_state = S_CK;
            end
            S_CK: begin
                // zero denominator also lands here as saturation
                n_zero  = (r_dmag == '0);
                n_sat   = (w_dmag_q >= r_den);
                n_state = w_div_req.start ? S_DW : S_FIN;
            end
            S_DW: begin
                if (w_div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold here while an earlier sample is still pending
                if (!r_out_valid || i_out_ready) begin
                    n_sample    = w_result;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_out_valid     <= 1'b0;
            r_sample_period <= SP_RESET;
            r_start_phase   <= SPH_RESET;
            r_pulse_width   <= PW_RESET;
            r_phase_a       <= f_q23_phase(f_offset(SPH_RESET, PW_RESET, 1'b0));
            r_phase_b       <= f_q23_phase(f_offset(SPH_RESET, PW_RESET, 1'b1));
            r_lsq_a         <= '0;
            r_lsq_b         <= '0;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_sample_period <= n_sample_period;
            r_start_phase   <= n_start_phase;
            r_pulse_width   <= n_pulse_width;
            r_phase_a       <= n_phase_a;
            r_phase_b       <= n_phase_b;
            r_lsq_a         <= n_lsq_a;
            r_lsq_b         <= n_lsq_b;
        end
        r_fmag   <= n_fmag;
        r_fneg   <= n_fneg;
        r_n31    <= n_n31;
        r_acc    <= n_acc;
        r_x      <= n_x;
        r_den    <= n_den;
        r_sa     <= n_sa;
        r_dmag   <= n_dmag;
        r_neg    <= n_neg;
        r_zero   <= n_zero;
        r_sat    <= n_sat;
        r_sample <= n_sample;
    end

`ifndef SYNTHESIS
    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && w_in_acc) |=> !o_in_ready)
        else $error("request accepted while a sample is in work");

    // 1 - n*T never drops below one half
    a_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DA) |-> (r_x[X_W-1] || r_x[X_W-2]))
        else $error("gain term 1 - n*T out of range");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DW))
        else $error("divider done outside its wait step");

    // stored squares stay within [0,1]
    a_square_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lsq_a <= 32'h8000_0000) && (r_lsq_b <= 32'h8000_0000))
        else $error("last square above one");
`endif

endmodule

// ===== test/tb_dpw_pulse_oscillator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dpw_pulse_oscillator
// self-checking bench for the dpw pulse oscillator: frequency requests are
// fed from a queue, every sample is checked against a bit-exact behavioral
// copy of the oscillator, under several register settings and idle patterns
// ----------------------------------------------------------------------------
module tb_dpw_pulse_oscillator;
    import dpw_pkg::*;

    localparam int PHASE_BITS   = 32;
    localparam int OUT_BITS     = 24;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SEGMENTS     = 6;
    localparam int STALL_LIMIT  = 5000;   // cycles without any handshake
    localparam int DRAIN_CYCLES = 100;    // well above the sample latency
    localparam int MAX_REPORTS  = 10;

    // index past the register list, the block must ignore it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // output saturation limits as magnitudes
    localparam logic [63:0] SAT_POS = (64'd1 << (OUT_BITS - 1)) - 64'd1;
    localparam logic [63:0] SAT_NEG = 64'd1 << (OUT_BITS - 1);

    // idle percentages of sender and receiver per stimulus segment
    typedef enum logic [1:0] {
        PACE_SLOW_SINK,
        PACE_SLOW_SOURCE,
        PACE_FULL_RATE
    } t_pace;

    typedef struct {
        logic signed [FREQ_W-1:0] freq;
        logic                     restart;
    } t_tone_req;

    // dut ports
    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_ready;
    logic signed [FREQ_W-1:0]   i_freq_hz   = '0;
    logic                       i_restart   = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [OUT_BITS-1:0] o_sample;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data  = '0;

    // stimulus and scoreboard
    t_tone_req                  pending_reqs[$];
    logic signed [OUT_BITS-1:0] expected_samples[$];
    logic                       req_taken    = 1'b0;
    int unsigned                tx_idle_pct  = 0;
    int unsigned                rx_idle_pct  = 0;
    int unsigned                fail_count   = 0;
    int unsigned                stall_cycles = 0;
    logic signed [OUT_BITS-1:0] predicted_sample;
    logic signed [OUT_BITS-1:0] wanted_sample;

    // oscillator copy: registers, two saw phases and their last squares
    logic [SP_W-1:0]       osc_period;
    logic [SPH_W-1:0]      osc_start;
    logic [PW_W-1:0]       osc_width;
    logic [PHASE_BITS-1:0] osc_phase_a;
    logic [PHASE_BITS-1:0] osc_phase_b;
    logic [63:0]           osc_sq_a;
    logic [63:0]           osc_sq_b;

    dpw_pulse_oscillator #(
        .PHASE_BITS (PHASE_BITS),
        .OUT_BITS   (OUT_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_freq_hz   (i_freq_hz),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample    (o_sample),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // oscillator copy
    // ------------------------------------------------------------------------

    // phase b sits twice the pulse width ahead, both wrap modulo 2
    task automatic reload_phases();
        logic [SPH_W-1:0] offset;
        offset      = osc_start + {osc_width, 1'b0};
        osc_phase_a = {osc_start, {(PHASE_BITS - SPH_W){1'b0}}};
        osc_phase_b = {offset, {(PHASE_BITS - SPH_W){1'b0}}};
        osc_sq_a    = '0;
        osc_sq_b    = '0;
    endtask

    // |phase| in Q.31 squared, result Q1.31 in [0,1]
    function automatic logic [63:0] phase_square(input logic [PHASE_BITS-1:0] p);
        logic [63:0] mag;
        mag = p[PHASE_BITS-1] ? (64'd1 << PHASE_BITS) - 64'(p) : 64'(p);
        mag = mag >> (PHASE_BITS - 32);
        return (mag * mag) >> 31;
    endfunction

    // one sample: advance both saws, difference the squares, apply the gain
    task automatic advance_pulse(input t_tone_req req,
                                 output logic signed [OUT_BITS-1:0] smp);
        logic [FREQ_W-1:0] fq;
        logic              neg_freq;
        logic              neg_out;
        logic [63:0]       fmag;
        logic [63:0]       prod;
        logic [63:0]       n31;
        logic [63:0]       nt23;
        logic [63:0]       den4;
        logic [63:0]       sq_a;
        logic [63:0]       sq_b;
        logic [63:0]       dmag;
        logic [63:0]       quo;
        logic [63:0]       wide;
        logic signed [63:0] diff;
        fq       = req.freq;
        neg_freq = fq[FREQ_W-1];
        fmag     = neg_freq ? (64'd1 << FREQ_W) - 64'(fq) : 64'(fq);
        if (req.restart) begin
            reload_phases();
        end
        prod = fmag * 64'(osc_period);
        n31  = prod >> 16;
        nt23 = (n31 * 64'(osc_period)) >> 48;
        den4 = ((n31 * ((64'd1 << 23) - nt23)) >> 23) << 2;
        // increment is added modulo 2, any size wraps
        wide        = prod >> (48 - PHASE_BITS);
        osc_phase_a = osc_phase_a + wide[PHASE_BITS-1:0];
        osc_phase_b = osc_phase_b + wide[PHASE_BITS-1:0];
        sq_a = phase_square(osc_phase_a);
        sq_b = phase_square(osc_phase_b);
        diff = ($signed(sq_a) - $signed(osc_sq_a)) - ($signed(sq_b) - $signed(osc_sq_b));
        osc_sq_a = sq_a;
        osc_sq_b = sq_b;
        dmag    = (diff < 0) ? 64'(-diff) : 64'(diff);
        neg_out = (diff < 0) != neg_freq;
        // vanishing denominator saturates the gain unless there is nothing to scale
        if (dmag == 0) begin
            quo = '0;
        end else if (den4 == 0) begin
            quo = SAT_NEG;
        end else begin
            quo = (dmag << (OUT_BITS - 2)) / den4;
        end
        if (neg_out) begin
            if (quo > SAT_NEG) begin
                quo = SAT_NEG;
            end
            wide = 64'd0 - quo;
        end else begin
            if (quo > SAT_POS) begin
                quo = SAT_POS;
            end
            wide = quo;
        end
        smp = wide[OUT_BITS-1:0];
    endtask

    // ------------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            // a new request only once the current one is gone
            if (!i_in_valid || req_taken) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_freq_hz  <= pending_reqs[0].freq;
                    i_restart  <= pending_reqs[0].restart;
                    pending_reqs.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: handshakes sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        req_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            // register writes land in the copy at the same edge
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD: osc_period = i_cfg_data[SP_W-1:0];
                    CFG_START_PHASE:   osc_start  = i_cfg_data[SPH_W-1:0];
                    CFG_PULSE_WIDTH:   osc_width  = i_cfg_data[PW_W-1:0];
                    default: ;
                endcase
            end
            // every accepted request yields exactly one sample
            if (i_in_valid && o_in_ready) begin
                advance_pulse('{freq: i_freq_hz, restart: i_restart}, predicted_sample);
                expected_samples.push_back(predicted_sample);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: sample %0d with no request pending", $realtime,
                                 o_sample);
                    end
                end else begin
                    wanted_sample = expected_samples.pop_front();
                    if (o_sample !== wanted_sample) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("%0t: sample mismatch, expected %0d actual %0d",
                                     $realtime, wanted_sample, o_sample);
                        end
                    end
                end
            end
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // writes all registers in index order plus the unmapped index, valid
    // stays high across the burst and drops once after the last write
    task automatic program_regs(input logic [SP_W-1:0] period,
                                input logic [SPH_W-1:0] phase0,
                                input logic [PW_W-1:0] width);
        logic [CFG_IDX_W-1:0] sel;
        for (int k = 0; k < 4; k++) begin
            sel = k[CFG_IDX_W-1:0];
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= sel;
            // bits above each register width are don't care, keep them moving
            case (sel)
                CFG_SAMPLE_PERIOD: i_cfg_data <= period;
                CFG_START_PHASE:   i_cfg_data <= {4'($urandom), phase0};
                CFG_PULSE_WIDTH:   i_cfg_data <= {5'($urandom), width};
                CFG_UNMAPPED:      i_cfg_data <= CFG_DATA_W'($urandom);
                default:           i_cfg_data <= CFG_DATA_W'($urandom);
            endcase
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until the queue is empty and every sample is back
    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_samples.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_SLOW_SINK:   begin tx_idle_pct = 9;  rx_idle_pct = 77; end
            PACE_SLOW_SOURCE: begin tx_idle_pct = 77; rx_idle_pct = 9;  end
            default:          begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        endcase
    endtask

    task automatic push_tone(input logic signed [FREQ_W-1:0] freq, input logic restart);
        pending_reqs.push_back('{freq: freq, restart: restart});
    endtask

    // mostly audio band, some low and near-zero tones, some raw bit patterns
    function automatic logic signed [FREQ_W-1:0] random_freq();
        logic [FREQ_W-1:0] mag;
        int unsigned       pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            mag = FREQ_W'($urandom_range(6144000));
        end else if (pick < 75) begin
            mag = FREQ_W'($urandom_range(25600));
        end else begin
            mag = FREQ_W'($urandom_range(3));
        end
        if (pick >= 85) begin
            return FREQ_W'($urandom);
        end
        return $urandom_range(1) ? -$signed(mag) : $signed(mag);
    endfunction

    initial begin
        logic signed [FREQ_W-1:0] tone;
        logic [SP_W-1:0]          period;
        logic [SPH_W-1:0]         phase0;
        logic [PW_W-1:0]          width;

        // copy starts from the reset state
        osc_period = SP_RESET;
        osc_start  = SPH_RESET;
        osc_width  = PW_RESET;
        reload_phases();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, first with the reset settings
        set_pace(PACE_SLOW_SINK);
        program_regs(SP_RESET, SPH_RESET, PW_RESET);
        push_tone('0, 1'b1);             // zero frequency, gain saturates
        push_tone(24'sd112640, 1'b0);    // 440 Hz
        push_tone(-24'sd112640, 1'b0);   // negative frequency inverts
        push_tone(24'sd6144000, 1'b0);
        push_tone(-24'sd6144000, 1'b0);
        push_tone(24'sh7FFFFF, 1'b0);    // field extremes
        push_tone(24'sh800000, 1'b0);
        push_tone(24'sd1, 1'b0);         // tiny frequency, small denominator
        push_tone(-24'sd1, 1'b0);
        push_tone('0, 1'b0);             // unchanged phases, zero difference
        push_tone(24'sd112640, 1'b1);    // restart in the middle of a run
        push_tone(24'sd5120000, 1'b0);
        push_tone(24'sd5120000, 1'b0);
        push_tone(24'sd256, 1'b0);
        drain();

        // zero sample period, gain always saturated
        program_regs('0, 24'h400000, PW_RESET);
        push_tone(24'sd112640, 1'b0);
        push_tone(-24'sd112640, 1'b1);
        push_tone('0, 1'b0);
        drain();

        // zero pulse width, both saws coincide and the output is silent
        program_regs(SP_RESET, 24'hC00000, '0);
        push_tone(24'sd112640, 1'b1);
        push_tone(-24'sd6144000, 1'b0);
        drain();

        // largest period with extreme tones, increments far beyond 2
        program_regs({SP_W{1'b1}}, 24'h7FFFFF, {PW_W{1'b1}});
        push_tone(24'sh7FFFFF, 1'b1);
        push_tone(24'sh800000, 1'b0);
        drain();

        // random part, one register setting per segment, drained in between
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0: begin period = SP_W'(1);       phase0 = 24'h800000; width = 23'h7FFFFF; end
                1: begin period = {SP_W{1'b1}};   phase0 = 24'h7FFFFF; width = '0;        end
                2: begin period = SP_RESET;       phase0 = 24'($urandom);
                         width = 23'($urandom); end
                3: begin period = 28'($urandom);  phase0 = 24'($urandom);
                         width = 23'($urandom); end
                4: begin period = 28'd137438953;  phase0 = SPH_RESET;  width = PW_RESET; end
                default: begin period = SP_W'($urandom_range(40000000, 10000000));
                         phase0 = 24'($urandom); width = 23'($urandom); end
            endcase
            if (seg < 2) begin
                set_pace(PACE_SLOW_SINK);
            end else if (seg < 4) begin
                set_pace(PACE_SLOW_SOURCE);
            end else begin
                set_pace(PACE_FULL_RATE);
            end
            program_regs(period, phase0, width);
            // tones held for runs like a real oscillator, with stray noise
            tone = random_freq();
            push_tone(tone, 1'b1);
            for (int n = 1; n < RANDOM_ITEMS / SEGMENTS; n++) begin
                if ($urandom_range(4) == 0) begin
                    tone = random_freq();
                end
                if ($urandom_range(9) == 0) begin
                    push_tone(FREQ_W'($urandom), 1'($urandom_range(1)));
                end else begin
                    push_tone(tone, $urandom_range(99) < 6);
                end
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/dpw_pkg.sv
rtl/dpw_mul.sv
rtl/dpw_div.sv
rtl/dpw_pulse_oscillator.sv
test/tb_dpw_pulse_oscillator.sv
